// ===== hw/rtl/gcr_pkg.sv =====
// Shared constants, command and state types of the grid raycast column block.
package gcr_pkg;

   localparam int FRAC_BITS         = 12;
   localparam int MAP_SIDE_LOG2_DEF = 6;
   localparam int MAX_COLUMNS_DEF   = 1024;

   localparam int POS_W     = 18;
   localparam int VEC_W     = 14;
   localparam int COL_W     = 10;
   localparam int TILE_C_W  = 6;
   localparam int TILE_V_W  = 8;
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 2;

   localparam int DIV_W  = 40;
   localparam int CAM_W  = 25;
   localparam int RAY_W  = 28;
   localparam int STEP_W = 2 * FRAC_BITS + 13;
   localparam int SIDE_W = 48;
   localparam int LH_W   = 13;
   localparam int DIST_W = 20;
   localparam int ROW_W  = 31;

   localparam int LINE_MAX = 8191;
   localparam int DIST_MAX = 1048575;
   localparam int SCREEN_WIDTH_RST  = 640;
   localparam int SCREEN_HEIGHT_RST = 480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_CAST  = 1'b1
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [TILE_C_W-1:0]       tile_x;
      logic [TILE_C_W-1:0]       tile_y;
      logic [TILE_V_W-1:0]       tile_value;
      logic [POS_W-1:0]          pos_x;
      logic [POS_W-1:0]          pos_y;
      logic signed [VEC_W-1:0]   dir_x;
      logic signed [VEC_W-1:0]   dir_y;
      logic signed [VEC_W-1:0]   cam_plane_x;
      logic signed [VEC_W-1:0]   cam_plane_y;
      logic [COL_W-1:0]          column;
   } cmd_type;

   typedef struct packed {
      logic [CSR_W-1:0] width;
      logic [CSR_W-1:0] height;
   } cfg_type;

   typedef enum logic [4:0] {
      BK_CLEAR, BK_IDLE, BK_CAM_GO, BK_CAM_WAIT, BK_RAY_MUL, BK_RAY_ADD,
      BK_DX_GO, BK_DX_WAIT, BK_DY_GO, BK_DY_WAIT, BK_SIDE, BK_STEP, BK_TEST,
      BK_DIST_GO, BK_DIST_WAIT, BK_LH_GO, BK_LH_WAIT, BK_ROWS, BK_DONE
   } back_state_type;

endpackage

// ===== hw/rtl/gcr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module gcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/gcr_div.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module gcr_div #(
   parameter int WIDTH = gcr_pkg::DIV_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] num,
   input  logic [WIDTH-1:0] den,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [WIDTH:0]   shift;
   logic [WIDTH:0]   diff;

   assign shift = {rem_ff, quo_ff[WIDTH-1]};
   assign diff  = shift - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         // keep the shifted partial remainder when the trial subtract borrows, else take the difference
         rem_in = diff[WIDTH] ? shift[WIDTH-1:0] : diff[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], ~diff[WIDTH]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/gcr_front.sv =====
// Request intake: classifies requests, drops off-map writes, queues commands.
module gcr_front #(
   parameter int MAP_SIDE_LOG2 = gcr_pkg::MAP_SIDE_LOG2_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  gcr_pkg::cmd_type      req_cmd,
   input  logic                  clearing,
   output logic                  cmd_valid,
   output gcr_pkg::cmd_type      cmd_data,
   input  logic                  cmd_pop
);

   gcr_pkg::cmd_type queue_ff [2];
   gcr_pkg::cmd_type queue_in [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             accept;
   logic             in_map;
   logic             enqueue;

   assign req_full  = (count_ff == 2'd2) || clearing;
   assign accept    = req_push && !req_full;
   assign in_map    = (32'(req_cmd.tile_x) < (1 << MAP_SIDE_LOG2)) &&
                      (32'(req_cmd.tile_y) < (1 << MAP_SIDE_LOG2));
   // drop writes that land outside the map
   assign enqueue   = accept && ((req_cmd.op == gcr_pkg::OP_CAST) || in_map);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      queue_in[0] = queue_ff[0];
      queue_in[1] = queue_ff[1];
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      if (enqueue) begin
         queue_in[wr_ptr_ff] = req_cmd;
         wr_ptr_in           = ~wr_ptr_ff;
      end
      if (cmd_pop && cmd_valid) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      count_in = count_ff + 2'(enqueue) - 2'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      queue_ff[0] <= queue_in[0];
      queue_ff[1] <= queue_in[1];
   end

endmodule

// ===== hw/rtl/gcr_back.sv =====
// Command engine: tile map store, ray setup, DDA walk, distance and row math.
module gcr_back #(
   parameter int MAP_SIDE_LOG2 = gcr_pkg::MAP_SIDE_LOG2_DEF,
   parameter int MAX_COLUMNS   = gcr_pkg::MAX_COLUMNS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gcr_pkg::cfg_type              cfg,
   input  logic                          cmd_valid,
   input  gcr_pkg::cmd_type              cmd_data,
   output logic                          cmd_pop,
   output logic                          clearing,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [gcr_pkg::COL_W-1:0]     rsp_column_out,
   output logic [9:0]                    rsp_draw_start,
   output logic [9:0]                    rsp_draw_end,
   output logic [gcr_pkg::LH_W-1:0]      rsp_line_height,
   output logic [gcr_pkg::DIST_W-1:0]    rsp_wall_distance,
   output logic                          rsp_x_side_hit,
   output logic signed [7:0]             rsp_hit_x,
   output logic signed [7:0]             rsp_hit_y,
   output logic signed [14:0]            rsp_floor_row,
   output logic signed [14:0]            rsp_ceiling_row
);

   localparam int F        = gcr_pkg::FRAC_BITS;
   localparam int L        = MAP_SIDE_LOG2;
   localparam int ADDR_W   = 2 * L;
   localparam int CELL_W   = ((L > gcr_pkg::TILE_C_W) ? L : gcr_pkg::TILE_C_W) + 2;
   localparam int NUM_W    = CELL_W + F + 2;
   localparam int WALK_CAP = 4 * (1 << L) + 8;
   localparam int WALK_W   = L + 4;
   localparam int STEP_W   = gcr_pkg::STEP_W;
   localparam int RAY_W    = gcr_pkg::RAY_W;
   localparam int DIV_W    = gcr_pkg::DIV_W;
   localparam int ROW_W    = gcr_pkg::ROW_W;
   localparam int PROD_W   = gcr_pkg::VEC_W + gcr_pkg::CAM_W;
   localparam int HS_W     = gcr_pkg::CSR_W + F;

   function automatic logic [RAY_W-1:0] ray_mag(input logic signed [RAY_W-1:0] v);
      return v[RAY_W-1] ? RAY_W'(-v) : RAY_W'(v);
   endfunction

   function automatic logic signed [ROW_W-1:0] half_trunc(
      input logic signed [ROW_W-1:0] v);
      logic signed [ROW_W-1:0] m;
      m = v[ROW_W-1] ? -v : v;
      m = m >>> (F + 1);
      return v[ROW_W-1] ? -m : m;
   endfunction

   function automatic logic [14:0] clamp_row(input logic signed [ROW_W-1:0] v);
      if (v < -16384) begin
         return 15'h4000;
      end
      if (v > 16383) begin
         return 15'h3FFF;
      end
      return v[14:0];
   endfunction

   gcr_pkg::back_state_type state_ff, state_in;
   gcr_pkg::cmd_type        cmd_ff, cmd_in;

   logic [ADDR_W-1:0]              clr_ff, clr_in;
   logic signed [gcr_pkg::CAM_W-1:0] cam_ff, cam_in;
   logic signed [PROD_W-1:0]       prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [RAY_W-1:0]        rx_ff, rx_in, ry_ff, ry_in;
   logic [STEP_W-1:0]              dx_ff, dx_in, dy_ff, dy_in;
   logic [gcr_pkg::SIDE_W-1:0]     sx_ff, sx_in, sy_ff, sy_in;
   logic signed [CELL_W-1:0]       cx_ff, cx_in, cy_ff, cy_in;
   logic                           xside_ff, xside_in;
   logic [WALK_W-1:0]              steps_ff, steps_in;
   logic [STEP_W-1:0]              dist_ff, dist_in;
   logic [gcr_pkg::LH_W-1:0]       lh_ff, lh_in;
   logic signed [27:0]             rowprod_ff, rowprod_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [gcr_pkg::COL_W-1:0]      col_ff, col_in;
   logic [9:0]                     dstart_ff, dstart_in, dend_ff, dend_in;
   logic [gcr_pkg::LH_W-1:0]       lh_out_ff, lh_out_in;
   logic [gcr_pkg::DIST_W-1:0]     dist_out_ff, dist_out_in;
   logic                           xs_out_ff, xs_out_in;
   logic signed [7:0]              hx_ff, hx_in, hy_ff, hy_in;
   logic signed [14:0]             floor_ff, floor_in, ceil_ff, ceil_in;

   logic                    div_start, div_done;
   logic [DIV_W-1:0]        div_num, div_den, div_q;
   logic                    ram_we, ram_re;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   logic [gcr_pkg::TILE_V_W-1:0] ram_wdata, ram_rdata;
   logic                    rsp_load;

   logic [gcr_pkg::CSR_W-1:0] w_eff, h_eff;
   logic [HS_W-1:0]           h_scaled;
   logic                      negx, negy, step_x;
   logic signed [CELL_W-1:0]  ncx, ncy;
   logic                      out_of_map, wall;
   logic [F:0]                mx, my;
   logic [F+STEP_W:0]         side_px, side_py;
   logic signed [NUM_W-1:0]   num_v;
   logic [NUM_W-1:0]          num_mag;
   logic signed [RAY_W-1:0]   sel_ray;
   logic [DIV_W-1:0]          dist_q;
   logic [9:0]                hh;
   logic [11:0]               lh2;
   logic signed [13:0]        start_v;
   logic [12:0]               end_v, end_c;
   logic signed [ROW_W-1:0]   floor_v, ceil_v;

   // effective screen size: zero reads as one, width capped at the column limit
   always_comb begin
      w_eff = cfg.width;
      if (cfg.width == '0) begin
         w_eff = gcr_pkg::CSR_W'(1);
      end else if (32'(cfg.width) > MAX_COLUMNS) begin
         w_eff = gcr_pkg::CSR_W'(MAX_COLUMNS);
      end
      h_eff = (cfg.height == '0) ? gcr_pkg::CSR_W'(1) : cfg.height;
   end

   assign h_scaled = HS_W'(h_eff) << F;
   assign negx     = rx_ff[RAY_W-1];
   assign negy     = ry_ff[RAY_W-1];
   assign step_x   = (sx_ff < sy_ff);
   assign ncx      = step_x ? (negx ? cx_ff - CELL_W'(1) : cx_ff + CELL_W'(1)) : cx_ff;
   assign ncy      = step_x ? cy_ff : (negy ? cy_ff - CELL_W'(1) : cy_ff + CELL_W'(1));

   assign out_of_map = cx_ff[CELL_W-1] || cy_ff[CELL_W-1] ||
                       (cx_ff[CELL_W-2:L] != '0) || (cy_ff[CELL_W-2:L] != '0);
   assign wall       = out_of_map || (ram_rdata != '0) || (steps_ff == WALK_W'(WALK_CAP));

   assign mx      = negx ? (F+1)'(cmd_ff.pos_x[F-1:0])
                         : (F+1)'(1 << F) - (F+1)'(cmd_ff.pos_x[F-1:0]);
   assign my      = negy ? (F+1)'(cmd_ff.pos_y[F-1:0])
                         : (F+1)'(1 << F) - (F+1)'(cmd_ff.pos_y[F-1:0]);
   assign side_px = mx * dx_ff;
   assign side_py = my * dy_ff;

   // offset from viewer to the crossed boundary on the last stepped axis
   always_comb begin
      if (xside_ff) begin
         num_v   = (NUM_W'(cx_ff) <<< F) - NUM_W'(cmd_ff.pos_x) +
                   (negx ? NUM_W'(1 << F) : NUM_W'(0));
         sel_ray = rx_ff;
      end else begin
         num_v   = (NUM_W'(cy_ff) <<< F) - NUM_W'(cmd_ff.pos_y) +
                   (negy ? NUM_W'(1 << F) : NUM_W'(0));
         sel_ray = ry_ff;
      end
      num_mag = num_v[NUM_W-1] ? NUM_W'(-num_v) : NUM_W'(num_v);
   end

   assign dist_q = div_q;

   // output row math
   assign hh      = h_eff[gcr_pkg::CSR_W-1:1];
   assign lh2     = lh_ff[gcr_pkg::LH_W-1:1];
   assign start_v = $signed(14'(hh)) - $signed(14'(lh2));
   assign end_v   = 13'(hh) + 13'(lh2);
   assign end_c   = (end_v > 13'(h_eff - gcr_pkg::CSR_W'(1))) ?
                    13'(h_eff - gcr_pkg::CSR_W'(1)) : end_v;
   assign floor_v = ROW_W'(rowprod_ff) + ROW_W'($signed({1'b0, h_scaled}));
   assign ceil_v  = ROW_W'($signed({1'b0, h_scaled})) -
                    ROW_W'($signed({1'b0, lh_ff, F'(0)})) -
                    ROW_W'(cmd_ff.cam_plane_y);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gcr_pkg::BK_CLEAR:     if (clr_ff == '1) state_in = gcr_pkg::BK_IDLE;
         gcr_pkg::BK_IDLE: begin
            if (cmd_valid && (cmd_data.op == gcr_pkg::OP_CAST)) begin
               state_in = gcr_pkg::BK_CAM_GO;
            end
         end
         gcr_pkg::BK_CAM_GO:    state_in = gcr_pkg::BK_CAM_WAIT;
         gcr_pkg::BK_CAM_WAIT:  if (div_done) state_in = gcr_pkg::BK_RAY_MUL;
         gcr_pkg::BK_RAY_MUL:   state_in = gcr_pkg::BK_RAY_ADD;
         gcr_pkg::BK_RAY_ADD:   state_in = gcr_pkg::BK_DX_GO;
         gcr_pkg::BK_DX_GO:     state_in = gcr_pkg::BK_DX_WAIT;
         gcr_pkg::BK_DX_WAIT:   if (div_done) state_in = gcr_pkg::BK_DY_GO;
         gcr_pkg::BK_DY_GO:     state_in = gcr_pkg::BK_DY_WAIT;
         gcr_pkg::BK_DY_WAIT:   if (div_done) state_in = gcr_pkg::BK_SIDE;
         gcr_pkg::BK_SIDE:      state_in = gcr_pkg::BK_STEP;
         gcr_pkg::BK_STEP:      state_in = gcr_pkg::BK_TEST;
         gcr_pkg::BK_TEST:      state_in = wall ? gcr_pkg::BK_DIST_GO : gcr_pkg::BK_STEP;
         gcr_pkg::BK_DIST_GO:   state_in = gcr_pkg::BK_DIST_WAIT;
         gcr_pkg::BK_DIST_WAIT: if (div_done) state_in = gcr_pkg::BK_LH_GO;
         gcr_pkg::BK_LH_GO:     state_in = gcr_pkg::BK_LH_WAIT;
         gcr_pkg::BK_LH_WAIT:   if (div_done) state_in = gcr_pkg::BK_ROWS;
         gcr_pkg::BK_ROWS:      state_in = gcr_pkg::BK_DONE;
         gcr_pkg::BK_DONE:      if (!rsp_valid_ff) state_in = gcr_pkg::BK_IDLE;
         default:               state_in = gcr_pkg::BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      cmd_pop   = 1'b0;
      clearing  = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = DIV_W'(1);
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = {ncy[L-1:0], ncx[L-1:0]};
      rsp_load  = 1'b0;
      case (state_ff)
         gcr_pkg::BK_CLEAR: begin
            clearing = 1'b1;
            ram_we   = 1'b1;
         end
         gcr_pkg::BK_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid && (cmd_data.op == gcr_pkg::OP_WRITE)) begin
               ram_we    = 1'b1;
               ram_waddr = {L'(cmd_data.tile_y), L'(cmd_data.tile_x)};
               ram_wdata = cmd_data.tile_value;
            end
         end
         gcr_pkg::BK_CAM_GO: begin
            div_start = 1'b1;
            div_num   = DIV_W'({cmd_ff.column, 1'b0}) << F;
            div_den   = DIV_W'(w_eff);
         end
         gcr_pkg::BK_DX_GO: begin
            div_start = 1'b1;
            div_num   = DIV_W'(1) << (2 * F);
            div_den   = (rx_ff == '0) ? DIV_W'(1) : DIV_W'(ray_mag(rx_ff));
         end
         gcr_pkg::BK_DY_GO: begin
            div_start = 1'b1;
            div_num   = DIV_W'(1) << (2 * F);
            div_den   = (ry_ff == '0) ? DIV_W'(1) : DIV_W'(ray_mag(ry_ff));
         end
         gcr_pkg::BK_STEP: begin
            ram_re = 1'b1;
         end
         gcr_pkg::BK_DIST_GO: begin
            div_start = 1'b1;
            div_num   = DIV_W'(num_mag) << F;
            div_den   = (sel_ray == '0) ? DIV_W'(1) : DIV_W'(ray_mag(sel_ray));
         end
         gcr_pkg::BK_LH_GO: begin
            div_start = 1'b1;
            div_num   = DIV_W'(h_scaled);
            div_den   = (dist_ff == '0) ? DIV_W'(1) : DIV_W'(dist_ff);
         end
         gcr_pkg::BK_DONE: begin
            rsp_load = !rsp_valid_ff;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      cmd_in     = cmd_ff;
      clr_in     = clr_ff;
      cam_in     = cam_ff;
      prodx_in   = prodx_ff;
      prody_in   = prody_ff;
      rx_in      = rx_ff;
      ry_in      = ry_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      xside_in   = xside_ff;
      steps_in   = steps_ff;
      dist_in    = dist_ff;
      lh_in      = lh_ff;
      rowprod_in = rowprod_ff;
      case (state_ff)
         gcr_pkg::BK_CLEAR:    clr_in = clr_ff + ADDR_W'(1);
         gcr_pkg::BK_IDLE:     if (cmd_valid) cmd_in = cmd_data;
         gcr_pkg::BK_CAM_WAIT: begin
            cam_in = $signed(gcr_pkg::CAM_W'(div_q)) - gcr_pkg::CAM_W'(1 << F);
         end
         gcr_pkg::BK_RAY_MUL: begin
            prodx_in = cmd_ff.cam_plane_x * cam_ff;
            prody_in = cmd_ff.cam_plane_y * cam_ff;
         end
         gcr_pkg::BK_RAY_ADD: begin
            rx_in = RAY_W'(cmd_ff.dir_x) + RAY_W'(prodx_ff >>> F);
            ry_in = RAY_W'(cmd_ff.dir_y) + RAY_W'(prody_ff >>> F);
         end
         gcr_pkg::BK_DX_WAIT: begin
            dx_in = (rx_ff == '0) ? STEP_W'(1) << (2 * F + 12) : STEP_W'(div_q);
         end
         gcr_pkg::BK_DY_WAIT: begin
            dy_in = (ry_ff == '0) ? STEP_W'(1) << (2 * F + 12) : STEP_W'(div_q);
         end
         gcr_pkg::BK_SIDE: begin
            sx_in    = gcr_pkg::SIDE_W'(side_px >> F);
            sy_in    = gcr_pkg::SIDE_W'(side_py >> F);
            cx_in    = CELL_W'(cmd_ff.pos_x[gcr_pkg::POS_W-1:F]);
            cy_in    = CELL_W'(cmd_ff.pos_y[gcr_pkg::POS_W-1:F]);
            xside_in = 1'b0;
            steps_in = '0;
         end
         gcr_pkg::BK_STEP: begin
            if (step_x) begin
               sx_in = sx_ff + gcr_pkg::SIDE_W'(dx_ff);
            end else begin
               sy_in = sy_ff + gcr_pkg::SIDE_W'(dy_ff);
            end
            cx_in    = ncx;
            cy_in    = ncy;
            xside_in = step_x;
            steps_in = steps_ff + WALK_W'(1);
         end
         gcr_pkg::BK_DIST_WAIT: begin
            dist_in = (sel_ray == '0) ? STEP_W'(1) << (2 * F + 12) : STEP_W'(dist_q);
         end
         gcr_pkg::BK_LH_WAIT: begin
            if ((dist_ff == '0) || (div_q > DIV_W'(gcr_pkg::LINE_MAX))) begin
               lh_in = gcr_pkg::LH_W'(gcr_pkg::LINE_MAX);
            end else begin
               lh_in = gcr_pkg::LH_W'(div_q);
            end
         end
         gcr_pkg::BK_ROWS: begin
            rowprod_in = $signed({1'b0, lh_ff}) * cmd_ff.cam_plane_y;
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      col_in       = col_ff;
      dstart_in    = dstart_ff;
      dend_in      = dend_ff;
      lh_out_in    = lh_out_ff;
      dist_out_in  = dist_out_ff;
      xs_out_in    = xs_out_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      floor_in     = floor_ff;
      ceil_in      = ceil_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         col_in       = cmd_ff.column;
         dstart_in    = start_v[13] ? 10'd0 : 10'(start_v);
         dend_in      = (end_c > 13'd1023) ? 10'd1023 : 10'(end_c);
         lh_out_in    = lh_ff;
         dist_out_in  = (dist_ff > STEP_W'(gcr_pkg::DIST_MAX)) ?
                        gcr_pkg::DIST_W'(gcr_pkg::DIST_MAX) : gcr_pkg::DIST_W'(dist_ff);
         xs_out_in    = xside_ff;
         hx_in        = 8'(cx_ff);
         hy_in        = 8'(cy_ff);
         floor_in     = clamp_row(half_trunc(floor_v));
         ceil_in      = clamp_row(half_trunc(ceil_v));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcr_pkg::BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      cam_ff      <= cam_in;
      prodx_ff    <= prodx_in;
      prody_ff    <= prody_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      xside_ff    <= xside_in;
      steps_ff    <= steps_in;
      dist_ff     <= dist_in;
      lh_ff       <= lh_in;
      rowprod_ff  <= rowprod_in;
      col_ff      <= col_in;
      dstart_ff   <= dstart_in;
      dend_ff     <= dend_in;
      lh_out_ff   <= lh_out_in;
      dist_out_ff <= dist_out_in;
      xs_out_ff   <= xs_out_in;
      hx_ff       <= hx_in;
      hy_ff       <= hy_in;
      floor_ff    <= floor_in;
      ceil_ff     <= ceil_in;
   end

   gcr_div #(.WIDTH(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   gcr_ram #(.WIDTH(gcr_pkg::TILE_V_W), .DEPTH(1 << ADDR_W)) u_tile_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_empty         = !rsp_valid_ff;
   assign rsp_column_out    = col_ff;
   assign rsp_draw_start    = dstart_ff;
   assign rsp_draw_end      = dend_ff;
   assign rsp_line_height   = lh_out_ff;
   assign rsp_wall_distance = dist_out_ff;
   assign rsp_x_side_hit    = xs_out_ff;
   assign rsp_hit_x         = hx_ff;
   assign rsp_hit_y         = hy_ff;
   assign rsp_floor_row     = floor_ff;
   assign rsp_ceiling_row   = ceil_ff;

endmodule

// ===== hw/rtl/grid_raycast_column.sv =====
// Top level of the DDA grid raycaster: config registers, intake and engine.
//
// Keeps a 2^MAP_SIDE_LOG2 square map of 8-bit tiles and casts one screen
// column per cast request, returning distance, slice height, draw span,
// floor/ceiling rows, hit tile and side flag. Write requests (operation 0)
// update one tile and produce no response; writes off the map are dropped.
// Requests enter through a two-entry command queue, so the requester can
// keep pushing while the engine works and a finished response waits for pop.
// Five divisions per cast run through one shared 40-bit radix-2 divider, and
// each DDA step waits for the registered read of the tile RAM.
// After reset the tile RAM is swept to zero, one tile per cycle, all
// 2^(2*MAP_SIDE_LOG2) tiles (4096 at the default); req_full stays high
// during the sweep. CSR writes are always taken and must only be issued
// while no request is in flight.
module grid_raycast_column #(
   parameter int MAP_SIDE_LOG2 = gcr_pkg::MAP_SIDE_LOG2_DEF,
   parameter int MAX_COLUMNS   = gcr_pkg::MAX_COLUMNS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_operation,
   input  logic [gcr_pkg::TILE_C_W-1:0]      req_tile_x,
   input  logic [gcr_pkg::TILE_C_W-1:0]      req_tile_y,
   input  logic [gcr_pkg::TILE_V_W-1:0]      req_tile_value,
   input  logic [gcr_pkg::POS_W-1:0]         req_pos_x,
   input  logic [gcr_pkg::POS_W-1:0]         req_pos_y,
   input  logic signed [gcr_pkg::VEC_W-1:0]  req_dir_x,
   input  logic signed [gcr_pkg::VEC_W-1:0]  req_dir_y,
   input  logic signed [gcr_pkg::VEC_W-1:0]  req_cam_plane_x,
   input  logic signed [gcr_pkg::VEC_W-1:0]  req_cam_plane_y,
   input  logic [gcr_pkg::COL_W-1:0]         req_column_in,

   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [gcr_pkg::COL_W-1:0]         rsp_column_out,
   output logic [9:0]                        rsp_draw_start,
   output logic [9:0]                        rsp_draw_end,
   output logic [gcr_pkg::LH_W-1:0]          rsp_line_height,
   output logic [gcr_pkg::DIST_W-1:0]        rsp_wall_distance,
   output logic                              rsp_x_side_hit,
   output logic signed [7:0]                 rsp_hit_x,
   output logic signed [7:0]                 rsp_hit_y,
   output logic signed [14:0]                rsp_floor_row,
   output logic signed [14:0]                rsp_ceiling_row,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gcr_pkg::CSR_W-1:0]         csr_wdata
);

   gcr_pkg::cfg_type cfg_ff, cfg_in;
   gcr_pkg::cmd_type req_cmd, cmd_data;
   logic             cmd_valid, cmd_pop, clearing;

   // CSR writes land at once; unknown indexes are ignored
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gcr_pkg::CSR_SCREEN_WIDTH:  cfg_in.width  = csr_wdata;
            gcr_pkg::CSR_SCREEN_HEIGHT: cfg_in.height = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= gcr_pkg::CSR_W'(gcr_pkg::SCREEN_WIDTH_RST);
         cfg_ff.height <= gcr_pkg::CSR_W'(gcr_pkg::SCREEN_HEIGHT_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // bundle the request fields into one command word
   always_comb begin
      req_cmd.op          = gcr_pkg::op_type'(req_operation);
      req_cmd.tile_x      = req_tile_x;
      req_cmd.tile_y      = req_tile_y;
      req_cmd.tile_value  = req_tile_value;
      req_cmd.pos_x       = req_pos_x;
      req_cmd.pos_y       = req_pos_y;
      req_cmd.dir_x       = req_dir_x;
      req_cmd.dir_y       = req_dir_y;
      req_cmd.cam_plane_x = req_cam_plane_x;
      req_cmd.cam_plane_y = req_cam_plane_y;
      req_cmd.column      = req_column_in;
   end

   gcr_front #(.MAP_SIDE_LOG2(MAP_SIDE_LOG2)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_cmd   (req_cmd),
      .clearing  (clearing),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   gcr_back #(.MAP_SIDE_LOG2(MAP_SIDE_LOG2), .MAX_COLUMNS(MAX_COLUMNS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd_valid         (cmd_valid),
      .cmd_data          (cmd_data),
      .cmd_pop           (cmd_pop),
      .clearing          (clearing),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_column_out    (rsp_column_out),
      .rsp_draw_start    (rsp_draw_start),
      .rsp_draw_end      (rsp_draw_end),
      .rsp_line_height   (rsp_line_height),
      .rsp_wall_distance (rsp_wall_distance),
      .rsp_x_side_hit    (rsp_x_side_hit),
      .rsp_hit_x         (rsp_hit_x),
      .rsp_hit_y         (rsp_hit_y),
      .rsp_floor_row     (rsp_floor_row),
      .rsp_ceiling_row   (rsp_ceiling_row)
   );

   // hold off requests for the whole reset sweep of the tile RAM
   a_full_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_full)
      else $error("request accepted during tile RAM sweep");

   // the draw span never inverts
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_draw_start <= rsp_draw_end))
      else $error("draw_start beyond draw_end");

   // a zero distance must give the saturated slice height
   a_zero_dist_sat: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_wall_distance == '0)) |->
      (rsp_line_height == gcr_pkg::LH_W'(gcr_pkg::LINE_MAX)))
      else $error("zero wall distance without saturated line height");

endmodule

// ===== tb/sv/gcr_column_checker.sv =====
// Column checker: predicts each cast response of the raycaster and compares it.
`timescale 1ns / 1ps
module gcr_column_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic                              req_full,
   input  logic                              req_operation,
   input  logic [gcr_pkg::TILE_C_W-1:0]      req_tile_x,
   input  logic [gcr_pkg::TILE_C_W-1:0]      req_tile_y,
   input  logic [gcr_pkg::TILE_V_W-1:0]      req_tile_value,
   input  logic [gcr_pkg::POS_W-1:0]         req_pos_x,
   input  logic [gcr_pkg::POS_W-1:0]         req_pos_y,
   input  logic signed [gcr_pkg::VEC_W-1:0]  req_dir_x,
   input  logic signed [gcr_pkg::VEC_W-1:0]  req_dir_y,
   input  logic signed [gcr_pkg::VEC_W-1:0]  req_cam_plane_x,
   input  logic signed [gcr_pkg::VEC_W-1:0]  req_cam_plane_y,
   input  logic [gcr_pkg::COL_W-1:0]         req_column_in,
   input  logic                              rsp_empty,
   input  logic                              rsp_pop,
   input  logic [gcr_pkg::COL_W-1:0]         rsp_column_out,
   input  logic [9:0]                        rsp_draw_start,
   input  logic [9:0]                        rsp_draw_end,
   input  logic [gcr_pkg::LH_W-1:0]          rsp_line_height,
   input  logic [gcr_pkg::DIST_W-1:0]        rsp_wall_distance,
   input  logic                              rsp_x_side_hit,
   input  logic signed [7:0]                 rsp_hit_x,
   input  logic signed [7:0]                 rsp_hit_y,
   input  logic signed [14:0]                rsp_floor_row,
   input  logic signed [14:0]                rsp_ceiling_row,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [gcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gcr_pkg::CSR_W-1:0]         csr_wdata,
   output int                                fail_count,
   output int                                pending_columns,
   output int                                columns_seen
);

   localparam longint ONE      = 64'sd1 << gcr_pkg::FRAC_BITS;
   localparam longint STEP_TOP = 64'sd1 << (2 * gcr_pkg::FRAC_BITS + 12);
   localparam int     SIDE     = 1 << gcr_pkg::MAP_SIDE_LOG2_DEF;
   localparam int     WALK_MAX = 4 * SIDE + 8;

   typedef struct packed {
      logic [gcr_pkg::COL_W-1:0]   column;
      logic [9:0]                  draw_start;
      logic [9:0]                  draw_end;
      logic [gcr_pkg::LH_W-1:0]    line_height;
      logic [gcr_pkg::DIST_W-1:0]  wall_distance;
      logic                        x_side;
      logic signed [7:0]           hit_x;
      logic signed [7:0]           hit_y;
      logic signed [14:0]          floor_row;
      logic signed [14:0]          ceiling_row;
   } column_result_type;

   logic [7:0]                 tile_copy [SIDE*SIDE];
   logic [gcr_pkg::CSR_W-1:0]  width_reg, height_reg;
   column_result_type          expected_columns [$];

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint absval(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic bit blocked(longint cx, longint cy);
      if (cx < 0 || cy < 0 || cx >= SIDE || cy >= SIDE) return 1'b1;
      return tile_copy[cy * SIDE + cx] != 8'd0;
   endfunction

   function automatic column_result_type predict_column(
      logic [gcr_pkg::POS_W-1:0] pos_x, logic [gcr_pkg::POS_W-1:0] pos_y,
      logic signed [gcr_pkg::VEC_W-1:0] dir_x, logic signed [gcr_pkg::VEC_W-1:0] dir_y,
      logic signed [gcr_pkg::VEC_W-1:0] pl_x, logic signed [gcr_pkg::VEC_W-1:0] pl_y,
      logic [gcr_pkg::COL_W-1:0] col);
      column_result_type r;
      longint w, h, cam, rx, ry, dx, dy, sx, sy, cx, cy, px, py, fx, fy;
      longint num, ray, wall_dist, lh, v;
      bit negx, negy, xside;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > gcr_pkg::MAX_COLUMNS_DEF) w = gcr_pkg::MAX_COLUMNS_DEF;
      h = height_reg;
      if (h < 1) h = 1;
      px = pos_x;
      py = pos_y;
      cam = (2 * longint'(col) * ONE) / w - ONE;
      // arithmetic shift gives the floor of the scaled product
      rx = longint'(dir_x) + ((longint'(pl_x) * cam) >>> gcr_pkg::FRAC_BITS);
      ry = longint'(dir_y) + ((longint'(pl_y) * cam) >>> gcr_pkg::FRAC_BITS);
      dx = (rx == 0) ? STEP_TOP : (ONE * ONE) / absval(rx);
      dy = (ry == 0) ? STEP_TOP : (ONE * ONE) / absval(ry);
      cx = px >>> gcr_pkg::FRAC_BITS;
      cy = py >>> gcr_pkg::FRAC_BITS;
      fx = px & (ONE - 1);
      fy = py & (ONE - 1);
      negx = rx < 0;
      negy = ry < 0;
      sx = ((negx ? fx : ONE - fx) * dx) >>> gcr_pkg::FRAC_BITS;
      sy = ((negy ? fy : ONE - fy) * dy) >>> gcr_pkg::FRAC_BITS;
      xside = 1'b0;
      for (int i = 0; i < WALK_MAX; i++) begin
         if (sx < sy) begin
            sx += dx;
            cx += negx ? -1 : 1;
            xside = 1'b1;
         end else begin
            sy += dy;
            cy += negy ? -1 : 1;
            xside = 1'b0;
         end
         if (blocked(cx, cy)) break;
      end
      if (xside) begin
         num = cx * ONE - px + (negx ? ONE : 0);
         ray = rx;
      end else begin
         num = cy * ONE - py + (negy ? ONE : 0);
         ray = ry;
      end
      wall_dist = (ray == 0) ? STEP_TOP : (absval(num) * ONE) / absval(ray);
      lh = (wall_dist == 0) ? gcr_pkg::LINE_MAX : (h * ONE) / wall_dist;
      if (lh > gcr_pkg::LINE_MAX) lh = gcr_pkg::LINE_MAX;
      r.column = col;
      r.draw_start = 10'(clamp(h / 2 - lh / 2, 0, 1023));
      v = h / 2 + lh / 2;
      if (v > h - 1) v = h - 1;
      r.draw_end = 10'(clamp(v, 0, 1023));
      r.line_height = gcr_pkg::LH_W'(lh);
      r.wall_distance = gcr_pkg::DIST_W'(clamp(wall_dist, 0, gcr_pkg::DIST_MAX));
      r.x_side = xside;
      r.hit_x = cx[7:0];
      r.hit_y = cy[7:0];
      v = (lh * longint'(pl_y) + h * ONE) / (2 * ONE);
      r.floor_row = 15'(clamp(v, -16384, 16383));
      v = (-lh * ONE - longint'(pl_y) + h * ONE) / (2 * ONE);
      r.ceiling_row = 15'(clamp(v, -16384, 16383));
      return r;
   endfunction

   assign pending_columns = expected_columns.size();

   always @(posedge clock) begin
      column_result_type seen, want;
      if (reset) begin
         foreach (tile_copy[i]) tile_copy[i] = 8'd0;
         width_reg  <= gcr_pkg::CSR_W'(gcr_pkg::SCREEN_WIDTH_RST);
         height_reg <= gcr_pkg::CSR_W'(gcr_pkg::SCREEN_HEIGHT_RST);
         expected_columns.delete();
         fail_count   <= 0;
         columns_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == gcr_pkg::CSR_SCREEN_WIDTH)  width_reg  <= csr_wdata;
            if (csr_index == gcr_pkg::CSR_SCREEN_HEIGHT) height_reg <= csr_wdata;
         end
         // retire the response first: a push in the same cycle is younger
         if (rsp_pop && !rsp_empty) begin
            columns_seen <= columns_seen + 1;
            seen = '{rsp_column_out, rsp_draw_start, rsp_draw_end, rsp_line_height,
                     rsp_wall_distance, rsp_x_side_hit, rsp_hit_x, rsp_hit_y,
                     rsp_floor_row, rsp_ceiling_row};
            if (expected_columns.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response: column %0d", rsp_column_out);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_columns.pop_front();
               if (seen !== want) begin
                  if (fail_count < 10) begin
                     $display("mismatch col/start/end/lh/dist/xs/hx/hy/floor/ceil");
                     $display("  exp %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                        want.column, want.draw_start, want.draw_end,
                        want.line_height, want.wall_distance, want.x_side,
                        want.hit_x, want.hit_y, want.floor_row, want.ceiling_row);
                     $display("  got %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                        seen.column, seen.draw_start, seen.draw_end,
                        seen.line_height, seen.wall_distance, seen.x_side,
                        seen.hit_x, seen.hit_y, seen.floor_row, seen.ceiling_row);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_push && !req_full) begin
            if (req_operation == gcr_pkg::OP_WRITE)
               tile_copy[{req_tile_y, req_tile_x}] = req_tile_value;
            else
               expected_columns.push_back(predict_column(req_pos_x, req_pos_y,
                  req_dir_x, req_dir_y, req_cam_plane_x, req_cam_plane_y,
                  req_column_in));
         end
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top of the grid raycaster: stimulus, response pacing and verdict.
`timescale 1ns / 1ps
module tb_top;

   // cycles without any handshake before the run is declared hung; covers
   // the reset sweep of the tile RAM and the longest cast several times over
   localparam int HANG_LIMIT = 40000;
   localparam int PHASE_ITEMS = 250;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_push = 1'b0;
   logic                             req_full;
   logic                             req_operation = gcr_pkg::OP_WRITE;
   logic [gcr_pkg::TILE_C_W-1:0]     req_tile_x = '0;
   logic [gcr_pkg::TILE_C_W-1:0]     req_tile_y = '0;
   logic [gcr_pkg::TILE_V_W-1:0]     req_tile_value = '0;
   logic [gcr_pkg::POS_W-1:0]        req_pos_x = '0;
   logic [gcr_pkg::POS_W-1:0]        req_pos_y = '0;
   logic signed [gcr_pkg::VEC_W-1:0] req_dir_x = '0;
   logic signed [gcr_pkg::VEC_W-1:0] req_dir_y = '0;
   logic signed [gcr_pkg::VEC_W-1:0] req_cam_plane_x = '0;
   logic signed [gcr_pkg::VEC_W-1:0] req_cam_plane_y = '0;
   logic [gcr_pkg::COL_W-1:0]        req_column_in = '0;
   logic                             rsp_empty;
   logic                             rsp_pop = 1'b0;
   logic [gcr_pkg::COL_W-1:0]        rsp_column_out;
   logic [9:0]                       rsp_draw_start, rsp_draw_end;
   logic [gcr_pkg::LH_W-1:0]         rsp_line_height;
   logic [gcr_pkg::DIST_W-1:0]       rsp_wall_distance;
   logic                             rsp_x_side_hit;
   logic signed [7:0]                rsp_hit_x, rsp_hit_y;
   logic signed [14:0]               rsp_floor_row, rsp_ceiling_row;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [gcr_pkg::CSR_IDX_W-1:0]    csr_index = gcr_pkg::CSR_SCREEN_WIDTH;
   logic [gcr_pkg::CSR_W-1:0]        csr_wdata = '0;

   int  fail_count, pending_columns, columns_seen;
   int  requests_sent = 0;
   int  idle_cycles = 0;
   int  pop_hold = 0;
   bit  pacing_on = 1'b1;

   always #1 clock = ~clock;

   grid_raycast_column u_dut (.*);

   gcr_column_checker u_checker (
      .clock, .reset, .req_push, .req_full, .req_operation, .req_tile_x,
      .req_tile_y, .req_tile_value, .req_pos_x, .req_pos_y, .req_dir_x,
      .req_dir_y, .req_cam_plane_x, .req_cam_plane_y, .req_column_in,
      .rsp_empty, .rsp_pop, .rsp_column_out, .rsp_draw_start, .rsp_draw_end,
      .rsp_line_height, .rsp_wall_distance, .rsp_x_side_hit, .rsp_hit_x,
      .rsp_hit_y, .rsp_floor_row, .rsp_ceiling_row, .csr_valid, .csr_ready,
      .csr_index, .csr_wdata, .fail_count, .pending_columns, .columns_seen
   );

   // Response side: after each accepted response, hold pop low for a drawn
   // number of cycles, then raise it until the next response is taken.
   always @(posedge clock) begin
      int wait_draw;
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (rsp_pop && !rsp_empty) begin
         wait_draw = pacing_on ? $urandom_range(0, 15) : 0;
         pop_hold <= wait_draw;
         rsp_pop  <= (wait_draw == 0);
      end else if (pop_hold > 1) begin
         pop_hold <= pop_hold - 1;
      end else begin
         pop_hold <= 0;
         rsp_pop  <= 1'b1;
      end
   end

   // Watchdog: count cycles in which no request, response or register write moves.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", HANG_LIMIT);
         $display("[grid_raycast_column] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Push one request; drop push only when a gap precedes it, so a
   // back-to-back request keeps push high without a second assignment.
   task automatic push_request(bit op, logic [5:0] tx, logic [5:0] ty,
                               logic [7:0] tv, logic [17:0] px, logic [17:0] py,
                               logic signed [13:0] dx, logic signed [13:0] dy,
                               logic signed [13:0] plx, logic signed [13:0] ply,
                               logic [9:0] col);
      int gap;
      gap = pacing_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_operation   <= gcr_pkg::op_type'(op);
      req_tile_x      <= tx;
      req_tile_y      <= ty;
      req_tile_value  <= tv;
      req_pos_x       <= px;
      req_pos_y       <= py;
      req_dir_x       <= dx;
      req_dir_y       <= dy;
      req_cam_plane_x <= plx;
      req_cam_plane_y <= ply;
      req_column_in   <= col;
      @(posedge clock);
      while (req_full) @(posedge clock);
      requests_sent++;
   endtask

   task automatic put_tile(int x, int y, int v);
      push_request(gcr_pkg::OP_WRITE, 6'(x), 6'(y), 8'(v), 18'($urandom),
                   18'($urandom), 14'($urandom), 14'($urandom), 14'($urandom),
                   14'($urandom), 10'($urandom));
   endtask

   task automatic cast(int px, int py, int dx, int dy, int plx, int ply, int col);
      push_request(gcr_pkg::OP_CAST, 6'($urandom), 6'($urandom), 8'($urandom),
                   18'(px), 18'(py), 14'(dx), 14'(dy), 14'(plx), 14'(ply), 10'(col));
   endtask

   // Drain every expected response, let a trailing tile write retire, then
   // write both screen registers while the block is idle.
   task automatic set_screen(int w, int h);
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_columns != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= gcr_pkg::CSR_SCREEN_WIDTH;
      csr_wdata <= gcr_pkg::CSR_W'(w);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= gcr_pkg::CSR_SCREEN_HEIGHT;
      csr_wdata <= gcr_pkg::CSR_W'(h);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         // sparse walls keep walks long; zero values erase earlier walls
         put_tile($urandom_range(0, 63), $urandom_range(0, 63),
                  ($urandom_range(0, 99) < 55) ? 0 : $urandom_range(1, 255));
      end else if (pick < 90) begin
         // unit-ish direction with a perpendicular plane, random position
         int d, p;
         d = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, 8192);
         p = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, 8192);
         if ($urandom_range(0, 1))
            cast($urandom, $urandom, d, p / 4, -p / 4 * 3, d / 2,
                 $urandom_range(0, 1023));
         else
            cast($urandom, $urandom, p / 3, d, d / 2, -p / 2,
                 $urandom_range(0, 1023));
      end else begin
         // noise: any bit pattern in every vector
         cast($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      int screens[7][2] = '{'{640, 480}, '{1, 1}, '{1024, 1024}, '{0, 0},
                            '{2047, 2047}, '{320, 200}, '{0, 0}};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: walls at the map corners, a wall hugging an integer position
      put_tile(0, 0, 255);
      put_tile(63, 63, 1);
      put_tile(4, 20, 128);
      cast(5 << 12, 20 << 12, -4096, 0, 0, 2703, 320);        // zero distance, max height
      cast(20 << 12, 20 << 12, 4096, 0, 0, 2703, 320);        // zero ray y, far wall outside
      cast(32 << 12, 32 << 12, 0, 0, 0, 0, 100);              // both ray parts zero
      cast(0, 0, -8192, -8192, 8191, -8192, 1023);            // extremes from the corner
      cast(262143, 262143, 8191, 8191, -8192, 8191, 639);
      cast(1 << 12, 1 << 12, -4096, -4096, 0, 0, 0);          // ray into the corner wall
      cast(62 << 12, 62 << 12, 4096, 4096, 2048, -2048, 1023);
      put_tile(0, 0, 0);
      cast(1 << 12, 1 << 12, -4096, -4096, 0, 0, 0);          // now reaches outside cells
      cast(2048, 262143, 0, 8191, 8191, 0, 512);
      put_tile(4, 20, 0);
      put_tile(63, 63, 0);

      foreach (screens[i]) begin
         if (i == 6) begin
            screens[i][0] = $urandom_range(1, 1024);
            screens[i][1] = $urandom_range(1, 1024);
         end
         set_screen(screens[i][0], screens[i][1]);
         // the second and fourth phases run flat out, without gaps on either side
         pacing_on = (i % 2 == 0) || (i == 5);
         repeat (PHASE_ITEMS) random_request();
      end

      req_push <= 1'b0;
      @(posedge clock);
      while (pending_columns != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("sent %0d requests, checked %0d column responses over 7 screen settings",
               requests_sent, columns_seen);
      if (fail_count == 0 && pending_columns == 0)
         $display("[grid_raycast_column] OK");
      else
         $display("[grid_raycast_column] ERROR");
      $finish;
   end

endmodule
